FILE: design/cwm_pkg.sv
package cwm_pkg;

   // Widths of the configuration registers and of the register index.
   localparam int CFG_ORDER_BITS = 4;
   localparam int CFG_Q16_BITS   = 17;
   localparam int CSR_INDEX_BITS = 2;

   // Unity in unsigned Q1.16.
   localparam logic [CFG_Q16_BITS-1:0] UNIT_Q16 = 17'd65536;

   // Reset values of the configuration registers.
   localparam logic [CFG_ORDER_BITS-1:0] RESET_POLY_ORDER   = 4'd2;
   localparam logic [CFG_Q16_BITS-1:0]   RESET_DRIVE_AMOUNT = 17'd0;
   localparam logic [CFG_Q16_BITS-1:0]   RESET_WET_MIX      = 17'd65536;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_POLY_ORDER   = 2'd0,
      CSR_DRIVE_AMOUNT = 2'd1,
      CSR_WET_MIX      = 2'd2
   } csr_index_type;

endpackage

FILE: design/chebyshev_waveshaper_mix.sv
// Chebyshev polynomial waveshaper with dry/wet blend.
// Requests arrive on the req_ stream: req_tdata carries one signed Q1.(N-1)
// sample. Each sample is scaled by 1 + 4*drive, clamped to [-1, 1], shaped by
// the Chebyshev polynomial T_n selected by poly_order (orders below 2 give T_2),
// blended with the dry sample by wet_mix and saturated. Results leave on the
// rsp_ stream, one per request, in order.
// Configuration is written over the csr_ port (index, data, valid/ready) and
// must only change while no request is in flight; csr_ready is always high.
// The drive gain has a multiply stage and a round-and-clamp stage, each of the
// MAX_ORDER-1 recurrence steps a product stage (multiply) and a round, subtract
// and clamp stage, and the blend a weighting stage and a sum-and-saturate stage.
// Throughput is one request per cycle while rsp_tready is high. Every stage
// holds its own valid bit, so a stall on rsp_tready only stops the run of full
// stages at the output end; the others keep filling and req_tready drops once
// the whole pipeline is occupied. Reset empties the pipeline and loads
// poly_order = 2, drive_amount = 0 and wet_mix = 1.0.
module chebyshev_waveshaper_mix
   import cwm_pkg::*;
#(
   parameter int SAMPLE_BITS = 24,
   parameter int MAX_ORDER   = 10
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // Request stream.
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]        req_tdata,  // [SAMPLE_BITS-1:0] sample_in
   // Result stream.
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]        rsp_tdata,  // [SAMPLE_BITS-1:0] sample_out
   // Configuration write port.
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]               csr_index,
   input  logic [CFG_Q16_BITS-1:0]                 csr_data
);

   localparam int SB    = SAMPLE_BITS;
   localparam int XW    = SB + 1;          // clamped value, may hold +1.0
   localparam int DW    = ((SB + 7) / 8) * 8;
   localparam int NSTEP = MAX_ORDER - 1;   // recurrence steps k = 2..MAX_ORDER
   localparam int GW    = 19;              // Q3.16 gain, up to 5.0
   localparam int P1W   = SB + GW + 1;
   localparam int RW    = SB + 3;          // rounded values before clamping
   localparam int PRW   = 2 * XW;
   localparam int BDW   = SB + 18;
   localparam int BWW   = XW + 18;
   localparam int SW    = SB + 20;

   localparam logic signed [RW-1:0] POS_ONE = RW'(64'sd1 <<< (SB - 1));
   localparam logic signed [RW-1:0] NEG_ONE = -POS_ONE;
   localparam logic signed [RW-1:0] POS_MAX = POS_ONE - RW'(1);

   // ---------------------------------------------------------------------
   // Configuration registers.
   logic [CFG_ORDER_BITS-1:0] poly_order_ff;
   logic [CFG_Q16_BITS-1:0]   drive_amount_ff;
   logic [CFG_Q16_BITS-1:0]   wet_mix_ff;

   assign csr_ready = 1'b1;

   // Writes to an unknown index are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         poly_order_ff   <= RESET_POLY_ORDER;
         drive_amount_ff <= RESET_DRIVE_AMOUNT;
         wet_mix_ff      <= RESET_WET_MIX;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_POLY_ORDER:   poly_order_ff   <= csr_data[CFG_ORDER_BITS-1:0];
            CSR_DRIVE_AMOUNT: drive_amount_ff <= csr_data;
            CSR_WET_MIX:      wet_mix_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   // Saturated drive gain and blend weights.
   logic [CFG_Q16_BITS-1:0] drive_sat;
   logic [CFG_Q16_BITS-1:0] mix_sat;
   logic [CFG_Q16_BITS-1:0] dry_weight;
   logic [GW-1:0]           gain;

   always_comb begin
      drive_sat  = (drive_amount_ff > UNIT_Q16) ? UNIT_Q16 : drive_amount_ff;
      mix_sat    = (wet_mix_ff > UNIT_Q16) ? UNIT_Q16 : wet_mix_ff;
      dry_weight = UNIT_Q16 - mix_sat;
      gain       = GW'(UNIT_Q16) + {drive_sat, 2'b00};
   end

   // ---------------------------------------------------------------------
   // Stage registers and the backward ready chain.
   logic                   s1_v_ff;
   logic signed [SB-1:0]   s1_dry_ff;
   logic signed [P1W-1:0]  s1_prod_ff;
   logic                   s2_v_ff;
   logic signed [SB-1:0]   s2_dry_ff;
   logic signed [XW-1:0]   s2_x_ff;
   logic                   b1_v_ff;
   logic signed [BDW-1:0]  b1_pdry_ff;
   logic signed [BWW-1:0]  b1_pwet_ff;
   logic                   b2_v_ff;
   logic signed [SB-1:0]   b2_out_ff;

   logic s1_rdy, s2_rdy, b1_rdy, b2_rdy;
   logic m_rdy [NSTEP];
   logic c_rdy [NSTEP];

   // Recurrence stage registers: m = product stage, c = clamp stage.
   logic                   mv_ff   [NSTEP];
   logic signed [SB-1:0]   mdry_ff [NSTEP];
   logic signed [XW-1:0]   mx_ff   [NSTEP];
   logic signed [XW-1:0]   mt0_ff  [NSTEP];
   logic signed [XW-1:0]   mt1_ff  [NSTEP];
   logic signed [PRW-1:0]  mprod_ff[NSTEP];
   logic                   cv_ff   [NSTEP];
   logic signed [SB-1:0]   cdry_ff [NSTEP];
   logic signed [XW-1:0]   cx_ff   [NSTEP];
   logic signed [XW-1:0]   ct0_ff  [NSTEP];
   logic signed [XW-1:0]   ct1_ff  [NSTEP];

   assign b2_rdy     = !b2_v_ff || rsp_tready;
   assign b1_rdy     = !b1_v_ff || b2_rdy;
   assign s2_rdy     = !s2_v_ff || m_rdy[0];
   assign s1_rdy     = !s1_v_ff || s2_rdy;
   assign req_tready = s1_rdy;

   // ---------------------------------------------------------------------
   // Stage 1: multiply the dry sample by the drive gain.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_rdy) begin
         s1_v_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         s1_dry_ff  <= $signed(req_tdata[SB-1:0]);
         s1_prod_ff <= $signed(req_tdata[SB-1:0]) * $signed({1'b0, gain});
      end
   end

   // Stage 2: round half away from zero and clamp to [-1, +1].
   logic signed [P1W:0]   s2_sum;
   logic signed [P1W:0]   s2_shr;
   logic signed [RW-1:0]  s2_r;
   logic signed [XW-1:0]  s2_x_in;

   always_comb begin
      s2_sum = {s1_prod_ff[P1W-1], s1_prod_ff} + (P1W+1)'(32768)
               - (P1W+1)'(s1_prod_ff[P1W-1]);
      s2_shr = s2_sum >>> 16;
      s2_r   = $signed(s2_shr[RW-1:0]);
      if (s2_r > POS_ONE) begin
         s2_x_in = POS_ONE[XW-1:0];
      end else if (s2_r < NEG_ONE) begin
         s2_x_in = NEG_ONE[XW-1:0];
      end else begin
         s2_x_in = s2_r[XW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_rdy) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_rdy) begin
         s2_dry_ff <= s1_dry_ff;
         s2_x_ff   <= s2_x_in;
      end
   end

   // ---------------------------------------------------------------------
   // Recurrence T_k = 2x*T_(k-1) - T_(k-2), one step per stage pair.
   // Steps beyond the configured order pass T_(k-2), T_(k-1) through.
   for (genvar j = 0; j < NSTEP; j++) begin : g_step
      logic                  src_v;
      logic signed [SB-1:0]  src_dry;
      logic signed [XW-1:0]  src_x;
      logic signed [XW-1:0]  src_t0;
      logic signed [XW-1:0]  src_t1;
      logic                  dn_rdy;
      logic                  active;
      logic signed [PRW:0]   c_sum;
      logic signed [PRW:0]   c_shr;
      logic signed [RW-1:0]  c_tn;
      logic signed [XW-1:0]  c_t1_in;

      if (j == 0) begin : g_first
         assign src_v   = s2_v_ff;
         assign src_dry = s2_dry_ff;
         assign src_x   = s2_x_ff;
         assign src_t0  = POS_ONE[XW-1:0];
         assign src_t1  = s2_x_ff;
      end else begin : g_next
         assign src_v   = cv_ff[j-1];
         assign src_dry = cdry_ff[j-1];
         assign src_x   = cx_ff[j-1];
         assign src_t0  = ct0_ff[j-1];
         assign src_t1  = ct1_ff[j-1];
      end

      if (j == NSTEP - 1) begin : g_last
         assign dn_rdy = b1_rdy;
      end else begin : g_mid
         assign dn_rdy = m_rdy[j+1];
      end

      assign m_rdy[j] = !mv_ff[j] || c_rdy[j];
      assign c_rdy[j] = !cv_ff[j] || dn_rdy;

      // Product stage.
      always_ff @(posedge clock) begin
         if (reset) begin
            mv_ff[j] <= 1'b0;
         end else if (m_rdy[j]) begin
            mv_ff[j] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (m_rdy[j]) begin
            mdry_ff[j]  <= src_dry;
            mx_ff[j]    <= src_x;
            mt0_ff[j]   <= src_t0;
            mt1_ff[j]   <= src_t1;
            mprod_ff[j] <= src_x * src_t1;
         end
      end

      // Round, subtract and clamp stage. Step j computes T_(j+2).
      always_comb begin
         active  = (j == 0) ||
                   ({1'b0, poly_order_ff} >= (CFG_ORDER_BITS+1)'(j + 2));
         c_sum   = {mprod_ff[j][PRW-1], mprod_ff[j]}
                   + ((PRW+1)'(1) <<< (SB - 3))
                   - (PRW+1)'(mprod_ff[j][PRW-1]);
         c_shr   = c_sum >>> (SB - 2);
         c_tn    = $signed(c_shr[RW-1:0]) - RW'(mt0_ff[j]);
         if (c_tn > POS_ONE) begin
            c_t1_in = POS_ONE[XW-1:0];
         end else if (c_tn < NEG_ONE) begin
            c_t1_in = NEG_ONE[XW-1:0];
         end else begin
            c_t1_in = c_tn[XW-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[j] <= 1'b0;
         end else if (c_rdy[j]) begin
            cv_ff[j] <= mv_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (c_rdy[j]) begin
            cdry_ff[j] <= mdry_ff[j];
            cx_ff[j]   <= mx_ff[j];
            if (active) begin
               ct0_ff[j] <= mt1_ff[j];
               ct1_ff[j] <= c_t1_in;
            end else begin
               ct0_ff[j] <= mt0_ff[j];
               ct1_ff[j] <= mt1_ff[j];
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Blend stage 1: weight the dry and the shaped sample.
   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff <= 1'b0;
      end else if (b1_rdy) begin
         b1_v_ff <= cv_ff[NSTEP-1];
      end
   end

   always_ff @(posedge clock) begin
      if (b1_rdy) begin
         b1_pdry_ff <= cdry_ff[NSTEP-1] * $signed({1'b0, dry_weight});
         b1_pwet_ff <= ct1_ff[NSTEP-1] * $signed({1'b0, mix_sat});
      end
   end

   // Blend stage 2: sum, round half away from zero and saturate.
   logic signed [SW-1:0]  b2_sum;
   logic signed [SW-1:0]  b2_shr;
   logic signed [RW-1:0]  b2_r;
   logic signed [SB-1:0]  b2_out_in;

   always_comb begin
      b2_sum = SW'(b1_pdry_ff) + SW'(b1_pwet_ff);
      b2_sum = b2_sum + SW'(32768) - SW'(b2_sum[SW-1]);
      b2_shr = b2_sum >>> 16;
      b2_r   = $signed(b2_shr[RW-1:0]);
      if (b2_r > POS_MAX) begin
         b2_out_in = POS_MAX[SB-1:0];
      end else if (b2_r < NEG_ONE) begin
         b2_out_in = NEG_ONE[SB-1:0];
      end else begin
         b2_out_in = b2_r[SB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b2_v_ff <= 1'b0;
      end else if (b2_rdy) begin
         b2_v_ff <= b1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b2_rdy) begin
         b2_out_ff <= b2_out_in;
      end
   end

   assign rsp_tvalid = b2_v_ff;
   assign rsp_tdata  = DW'(unsigned'(b2_out_ff));

endmodule
